// File: src/sbc_pkg.sv
// sbc_pkg: widths, constants and the divider result type for the segment/box clipper.
// Shared by sbc_div, segment_box_clip, sbc_checker and tb_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sbc_pkg;

    localparam int COORD_W       = 32;
    localparam int DIR_W         = COORD_W + 1;   // exact difference of two coordinates
    localparam int FRAC_W        = 16;
    localparam int NUM_W         = DIR_W + FRAC_W; // |num| scaled by 1.0
    localparam int Q_W           = 18;            // quotient bits kept before clamping
    localparam int REM_W         = NUM_W + 2;     // room for divisor << (Q_W - 1)
    localparam int T_W           = 19;            // signed plane parameter, [-1.0, 2.0]
    localparam int PAR_W         = 17;            // reported parameter width
    localparam int PROD_W        = DIR_W + T_W;
    localparam int BITS_PER_STEP = 2;
    localparam int DIV_STEPS     = Q_W / BITS_PER_STEP;
    localparam int NUM_AXES      = 3;

    localparam int T_ONE = 65536;
    localparam int T_MAX = 131072;

    typedef struct packed {
        logic [Q_W-1:0] quo;
        logic           neg;
        logic           ovf;
    } div_res_t;

endpackage
`default_nettype wire

// File: src/sbc_div.sv
// sbc_div: pipelined restoring divider, trunc(|num| * 1.0 / |den|) with overflow flag.
// One stage of set-up then DIV_STEPS stages of BITS_PER_STEP bits; uses sbc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbc_div
    import sbc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic [DIV_STEPS:0]      en,
    input  wire logic signed [DIR_W-1:0] num,
    input  wire logic signed [DIR_W-1:0] den,
    output div_res_t                     res
);

    logic [NUM_W-1:0] rem_reg [DIV_STEPS+1];
    logic [DIR_W-1:0] dsr_reg [DIV_STEPS+1];
    logic [Q_W-1:0]   quo_reg [DIV_STEPS+1];
    logic             neg_reg [DIV_STEPS+1];
    logic             ovf_reg [DIV_STEPS+1];

    logic [DIR_W-1:0] num_mag;
    logic [DIR_W-1:0] den_mag;
    logic [NUM_W-1:0] num_sh;
    logic             ovf_c;

    always_comb
    begin
        num_mag = num[DIR_W-1] ? DIR_W'(-num) : DIR_W'(num);
        den_mag = den[DIR_W-1] ? DIR_W'(-den) : DIR_W'(den);
        num_sh  = {num_mag, FRAC_W'(0)};
        // quotient would not fit in Q_W bits
        ovf_c   = REM_W'(num_sh) >= (REM_W'(den_mag) << Q_W);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= num_sh;
            dsr_reg[0] <= den_mag;
            quo_reg[0] <= '0;
            neg_reg[0] <= num[DIR_W-1] ^ den[DIR_W-1];
            ovf_reg[0] <= ovf_c;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++)
    begin : g_step
        logic [NUM_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;

        always_comb
        begin
            logic [REM_W-1:0] r;
            logic [REM_W-1:0] cand;
            r        = REM_W'(rem_reg[j-1]);
            quo_next = quo_reg[j-1];
            for (int k = 0; k < BITS_PER_STEP; k++)
            begin
                cand = REM_W'(dsr_reg[j-1]) << (Q_W - 1 - BITS_PER_STEP * (j - 1) - k);
                if (r >= cand)
                begin
                    r = r - cand;
                    quo_next[Q_W - 1 - BITS_PER_STEP * (j - 1) - k] = 1'b1;
                end
            end
            rem_next = r[NUM_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= rem_next;
                dsr_reg[j] <= dsr_reg[j-1];
                quo_reg[j] <= quo_next;
                neg_reg[j] <= neg_reg[j-1];
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign res = '{quo: quo_reg[DIV_STEPS], neg: neg_reg[DIV_STEPS], ovf: ovf_reg[DIV_STEPS]};

endmodule
`default_nettype wire

// File: src/segment_box_clip.sv
// segment_box_clip: slab clipping of a 3D segment against an axis-aligned box.
// One transaction per cycle sustained while out_ready stays high.
// Depth is set by an input stage, a set-up stage, the six plane dividers (18 quotient
// bits, two per stage, nine stages) and a clamp stage, then three slab stages, one
// multiply stage and one endpoint stage. Each stage holds its item under back-pressure
// and fills bubbles. Reset clears all valid bits.
// Uses sbc_pkg and sbc_div.
`timescale 1ns / 1ps
`default_nettype none
module segment_box_clip
    import sbc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic signed [COORD_W-1:0] box_min_x,
    input  wire logic signed [COORD_W-1:0] box_min_y,
    input  wire logic signed [COORD_W-1:0] box_min_z,
    input  wire logic signed [COORD_W-1:0] box_max_x,
    input  wire logic signed [COORD_W-1:0] box_max_y,
    input  wire logic signed [COORD_W-1:0] box_max_z,
    input  wire logic signed [COORD_W-1:0] seg_start_x,
    input  wire logic signed [COORD_W-1:0] seg_start_y,
    input  wire logic signed [COORD_W-1:0] seg_start_z,
    input  wire logic signed [COORD_W-1:0] seg_end_x,
    input  wire logic signed [COORD_W-1:0] seg_end_y,
    input  wire logic signed [COORD_W-1:0] seg_end_z,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           hit,
    output logic [PAR_W-1:0]               enter_param,
    output logic [PAR_W-1:0]               exit_param,
    output logic signed [COORD_W-1:0]      clip_start_x,
    output logic signed [COORD_W-1:0]      clip_start_y,
    output logic signed [COORD_W-1:0]      clip_start_z,
    output logic signed [COORD_W-1:0]      clip_end_x,
    output logic signed [COORD_W-1:0]      clip_end_y,
    output logic signed [COORD_W-1:0]      clip_end_z
);

    localparam int NST      = 17;
    localparam int ST_DIV   = 1;
    localparam int ST_CLAMP = ST_DIV + DIV_STEPS + 1;
    localparam int ST_SLAB  = ST_CLAMP + 1;
    localparam int ST_MUL   = ST_SLAB + NUM_AXES;
    localparam int ST_OUT   = ST_MUL + 1;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] s;
        logic [NUM_AXES-1:0][DIR_W-1:0]   d;
        logic [NUM_AXES-1:0]              slo;
        logic [NUM_AXES-1:0]              shi;
    } carry_t;

    typedef struct packed {
        logic signed [T_W-1:0] t0;
        logic signed [T_W-1:0] t1;
        logic                  alive;
    } slab_t;

    function automatic logic signed [T_W-1:0] clamp_t(input div_res_t r);
        logic [Q_W-1:0] mag;
        if (r.neg)
        begin
            mag = (r.ovf || r.quo > Q_W'(T_ONE)) ? Q_W'(T_ONE) : r.quo;
            return -T_W'(mag);
        end
        mag = (r.ovf || r.quo > Q_W'(T_MAX)) ? Q_W'(T_MAX) : r.quo;
        return T_W'(mag);
    endfunction

    function automatic slab_t slab_fn(input slab_t in, input logic signed [T_W-1:0] tlo,
                                      input logic signed [T_W-1:0] thi,
                                      input logic [DIR_W-1:0] d,
                                      input logic slo, input logic shi);
        slab_t o;
        logic  pos;
        logic  neg;
        o   = in;
        neg = d[DIR_W-1];
        pos = !neg && (d != '0);
        // min plane
        if (pos)
        begin
            if (tlo > o.t1)      o.alive = 1'b0;
            else if (tlo > o.t0) o.t0 = tlo;
        end
        else if (neg)
        begin
            if (tlo < o.t0)      o.alive = 1'b0;
            else if (tlo < o.t1) o.t1 = tlo;
        end
        else if (slo)
            o.alive = 1'b0;
        // max plane
        if (pos)
        begin
            if (thi < o.t0)      o.alive = 1'b0;
            else if (thi < o.t1) o.t1 = thi;
        end
        else if (neg)
        begin
            if (thi > o.t1)      o.alive = 1'b0;
            else if (thi > o.t0) o.t0 = thi;
        end
        else if (shi)
            o.alive = 1'b0;
        o.alive = o.alive && in.alive;
        return o;
    endfunction

    logic [NST-1:0] v_reg;
    logic [NST:0]   en;

    // a stage advances when it is empty or the next one advances
    always_comb
    begin
        en[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
        end
    end

    // stage 0: input capture
    logic signed [COORD_W-1:0] lo_reg [NUM_AXES];
    logic signed [COORD_W-1:0] hi_reg [NUM_AXES];
    logic signed [COORD_W-1:0] st_reg [NUM_AXES];
    logic signed [COORD_W-1:0] ed_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo_reg[0] <= box_min_x;   lo_reg[1] <= box_min_y;   lo_reg[2] <= box_min_z;
            hi_reg[0] <= box_max_x;   hi_reg[1] <= box_max_y;   hi_reg[2] <= box_max_z;
            st_reg[0] <= seg_start_x; st_reg[1] <= seg_start_y; st_reg[2] <= seg_start_z;
            ed_reg[0] <= seg_end_x;   ed_reg[1] <= seg_end_y;   ed_reg[2] <= seg_end_z;
        end
    end

    // stage 1 set-up: differences and start-outside-slab tests
    logic signed [DIR_W-1:0] dir_c  [NUM_AXES];
    logic signed [DIR_W-1:0] numl_c [NUM_AXES];
    logic signed [DIR_W-1:0] numh_c [NUM_AXES];
    carry_t                  car_c;
    div_res_t                dlo    [NUM_AXES];
    div_res_t                dhi    [NUM_AXES];

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dir_c[a]    = DIR_W'(ed_reg[a]) - DIR_W'(st_reg[a]);
            numl_c[a]   = DIR_W'(lo_reg[a]) - DIR_W'(st_reg[a]);
            numh_c[a]   = DIR_W'(hi_reg[a]) - DIR_W'(st_reg[a]);
            car_c.s[a]  = st_reg[a];
            car_c.d[a]  = dir_c[a];
            car_c.slo[a] = st_reg[a] < lo_reg[a];
            car_c.shi[a] = st_reg[a] > hi_reg[a];
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        sbc_div u_div_lo (
            .clk (clk),
            .en  (en[ST_DIV + DIV_STEPS:ST_DIV]),
            .num (numl_c[a]),
            .den (dir_c[a]),
            .res (dlo[a])
        );
        sbc_div u_div_hi (
            .clk (clk),
            .en  (en[ST_DIV + DIV_STEPS:ST_DIV]),
            .num (numh_c[a]),
            .den (dir_c[a]),
            .res (dhi[a])
        );
    end

    carry_t car_reg [ST_DIV:ST_MUL];

    always_ff @(posedge clk)
    begin
        if (en[ST_DIV])
            car_reg[ST_DIV] <= car_c;
        for (int k = ST_DIV + 1; k <= ST_MUL; k++)
            if (en[k])
                car_reg[k] <= car_reg[k-1];
    end

    // clamp stage, then plane parameters travel with the slab stages
    logic signed [T_W-1:0] tlo_reg [ST_CLAMP:ST_SLAB+1][NUM_AXES];
    logic signed [T_W-1:0] thi_reg [ST_CLAMP:ST_SLAB+1][NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (en[ST_CLAMP])
            for (int a = 0; a < NUM_AXES; a++)
            begin
                tlo_reg[ST_CLAMP][a] <= clamp_t(dlo[a]);
                thi_reg[ST_CLAMP][a] <= clamp_t(dhi[a]);
            end
        for (int k = ST_CLAMP + 1; k <= ST_SLAB + 1; k++)
            if (en[k])
            begin
                tlo_reg[k] <= tlo_reg[k-1];
                thi_reg[k] <= thi_reg[k-1];
            end
    end

    // slab stages: x, then y, then z
    slab_t slab_reg [NUM_AXES];
    slab_t slab_init;

    assign slab_init = '{t0: '0, t1: T_W'(T_ONE), alive: 1'b1};

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NUM_AXES; a++)
            if (en[ST_SLAB + a])
                slab_reg[a] <= slab_fn((a == 0) ? slab_init : slab_reg[(a == 0) ? 0 : a - 1],
                                       tlo_reg[ST_CLAMP + a][a], thi_reg[ST_CLAMP + a][a],
                                       car_reg[ST_CLAMP + a].d[a],
                                       car_reg[ST_CLAMP + a].slo[a],
                                       car_reg[ST_CLAMP + a].shi[a]);
    end

    // multiply stage
    logic signed [PROD_W-1:0] p0_reg [NUM_AXES];
    logic signed [PROD_W-1:0] p1_reg [NUM_AXES];
    slab_t                    fin_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            fin_reg <= slab_reg[NUM_AXES-1];
            for (int a = 0; a < NUM_AXES; a++)
            begin
                p0_reg[a] <= PROD_W'($signed(car_reg[ST_MUL-1].d[a])) *
                             PROD_W'(slab_reg[NUM_AXES-1].t0);
                p1_reg[a] <= PROD_W'($signed(car_reg[ST_MUL-1].d[a])) *
                             PROD_W'(slab_reg[NUM_AXES-1].t1);
            end
        end
    end

    // endpoint stage: arithmetic shift gives the floor; zero everything on a miss
    logic                      hit_reg;
    logic [PAR_W-1:0]          ent_reg;
    logic [PAR_W-1:0]          ext_reg;
    logic signed [COORD_W-1:0] cs_reg [NUM_AXES];
    logic signed [COORD_W-1:0] ce_reg [NUM_AXES];

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            hit_reg <= fin_reg.alive;
            ent_reg <= fin_reg.alive ? fin_reg.t0[PAR_W-1:0] : '0;
            ext_reg <= fin_reg.alive ? fin_reg.t1[PAR_W-1:0] : '0;
            for (int a = 0; a < NUM_AXES; a++)
            begin
                cs_reg[a] <= fin_reg.alive ?
                    COORD_W'(car_reg[ST_MUL].s[a] + p0_reg[a][FRAC_W +: COORD_W]) : '0;
                ce_reg[a] <= fin_reg.alive ?
                    COORD_W'(car_reg[ST_MUL].s[a] + p1_reg[a][FRAC_W +: COORD_W]) : '0;
            end
        end
    end

    assign hit          = hit_reg;
    assign enter_param  = ent_reg;
    assign exit_param   = ext_reg;
    assign clip_start_x = cs_reg[0];
    assign clip_start_y = cs_reg[1];
    assign clip_start_z = cs_reg[2];
    assign clip_end_x   = ce_reg[0];
    assign clip_end_y   = ce_reg[1];
    assign clip_end_z   = ce_reg[2];

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> enter_param == '0 && exit_param == '0 && clip_start_x == '0)
        else $error("miss result not cleared");

    a_param_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> enter_param <= exit_param && exit_param <= PAR_W'(T_ONE))
        else $error("clip parameters out of order");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled with no result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(enter_param) && $stable(clip_end_z))
        else $error("stalled result changed");

endmodule
`default_nettype wire

// File: dv/sbc_checker.sv
// sbc_checker: watches both channels of segment_box_clip, predicts each clip result
// and compares the whole result, printing each field on a mismatch. Depends on sbc_pkg for widths.
`timescale 1ns / 1ps
module sbc_checker
    import sbc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic signed [COORD_W-1:0] box_min_x,
    input  logic signed [COORD_W-1:0] box_min_y,
    input  logic signed [COORD_W-1:0] box_min_z,
    input  logic signed [COORD_W-1:0] box_max_x,
    input  logic signed [COORD_W-1:0] box_max_y,
    input  logic signed [COORD_W-1:0] box_max_z,
    input  logic signed [COORD_W-1:0] seg_start_x,
    input  logic signed [COORD_W-1:0] seg_start_y,
    input  logic signed [COORD_W-1:0] seg_start_z,
    input  logic signed [COORD_W-1:0] seg_end_x,
    input  logic signed [COORD_W-1:0] seg_end_y,
    input  logic signed [COORD_W-1:0] seg_end_z,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      hit,
    input  logic [PAR_W-1:0]          enter_param,
    input  logic [PAR_W-1:0]          exit_param,
    input  logic signed [COORD_W-1:0] clip_start_x,
    input  logic signed [COORD_W-1:0] clip_start_y,
    input  logic signed [COORD_W-1:0] clip_start_z,
    input  logic signed [COORD_W-1:0] clip_end_x,
    input  logic signed [COORD_W-1:0] clip_end_y,
    input  logic signed [COORD_W-1:0] clip_end_z,
    output int                        fail_count,
    output int                        pending
);

    typedef struct packed {
        logic                    hit;
        logic [PAR_W-1:0]        t_in;
        logic [PAR_W-1:0]        t_out;
        logic [6*COORD_W-1:0]    pts;   // start x,y,z then end x,y,z, x in the top word
    } clip_res_t;

    clip_res_t clip_q[$];

    assign pending = clip_q.size();

    function automatic longint plane_t(longint num, longint den);
        longint t;
        t = (num * T_ONE) / den;
        if (t < -T_ONE) t = -T_ONE;
        if (t > T_MAX) t = T_MAX;
        return t;
    endfunction

    // Returns 0 when the slab rejects the segment.
    function automatic bit slab_clip(longint lo, longint hi, longint s, longint d,
                                     inout longint t0, inout longint t1);
        longint t;
        if (d > 0) begin
            t = plane_t(lo - s, d);
            if (t > t1) return 0;
            if (t > t0) t0 = t;
            t = plane_t(hi - s, d);
            if (t < t0) return 0;
            if (t < t1) t1 = t;
        end
        else if (d < 0) begin
            t = plane_t(lo - s, d);
            if (t < t0) return 0;
            if (t < t1) t1 = t;
            t = plane_t(hi - s, d);
            if (t > t1) return 0;
            if (t > t0) t0 = t;
        end
        else if (s < lo || s > hi) begin
            return 0;
        end
        return 1;
    endfunction

    function automatic logic [COORD_W-1:0] point_on(longint s, longint d, longint t);
        longint p;
        longint q;
        p = d * t;
        q = p / T_ONE;
        if (p < 0 && (p % T_ONE) != 0) q -= 1;
        return COORD_W'(s + q);
    endfunction

    function automatic clip_res_t predict_clip(longint lo[3], longint hi[3],
                                               longint s[3], longint e[3]);
        clip_res_t r;
        longint    d[3];
        longint    t0;
        longint    t1;
        r = '0;
        t0 = 0;
        t1 = T_ONE;
        for (int a = 0; a < NUM_AXES; a++) d[a] = e[a] - s[a];
        for (int a = 0; a < NUM_AXES; a++)
            if (!slab_clip(lo[a], hi[a], s[a], d[a], t0, t1)) return r;
        r.hit   = 1'b1;
        r.t_in  = PAR_W'(t0);
        r.t_out = PAR_W'(t1);
        for (int a = 0; a < NUM_AXES; a++) begin
            r.pts[(5-a)*COORD_W +: COORD_W] = point_on(s[a], d[a], t0);
            r.pts[(2-a)*COORD_W +: COORD_W] = point_on(s[a], d[a], t1);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint    lo[3];
        longint    hi[3];
        longint    s[3];
        longint    e[3];
        clip_res_t got;
        clip_res_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            clip_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                lo = '{box_min_x, box_min_y, box_min_z};
                hi = '{box_max_x, box_max_y, box_max_z};
                s  = '{seg_start_x, seg_start_y, seg_start_z};
                e  = '{seg_end_x, seg_end_y, seg_end_z};
                clip_q.push_back(predict_clip(lo, hi, s, e));
            end
            if (out_valid && out_ready)
            begin
                got = {hit, enter_param, exit_param, clip_start_x, clip_start_y,
                       clip_start_z, clip_end_x, clip_end_y, clip_end_z};
                if (clip_q.size() == 0)
                begin
                    if (fail_count < 10) $display("ERROR: result with none expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = clip_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: hit %0b/%0b t0 %0d/%0d t1 %0d/%0d pts %h/%h",
                                     want.hit, got.hit, want.t_in, got.t_in,
                                     want.t_out, got.t_out, want.pts, got.pts);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: dv/tb_top.sv
// tb_top: stimulus and verdict for segment_box_clip; directed corners then random
// segments and boxes under random idling. Depends on sbc_pkg and sbc_checker.
`timescale 1ns / 1ps
module tb_top;
    import sbc_pkg::*;

    localparam int N_RANDOM   = 1250;
    localparam int WD_LIMIT   = 5000;
    localparam int HOLD_START = 1000;
    localparam int HOLD_LEN   = 150;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    logic signed [COORD_W-1:0] bmin[3] = '{0, 0, 0};
    logic signed [COORD_W-1:0] bmax[3] = '{0, 0, 0};
    logic signed [COORD_W-1:0] ps[3] = '{0, 0, 0};
    logic signed [COORD_W-1:0] pe[3] = '{0, 0, 0};
    logic                      hit;
    logic [PAR_W-1:0]          enter_param;
    logic [PAR_W-1:0]          exit_param;
    logic signed [COORD_W-1:0] cs[3];
    logic signed [COORD_W-1:0] ce[3];
    int  fail_count;
    int  pending;
    bit  quiet_mode = 0;     // no idling on either side
    int  rx_cycle = 0;       // receiver's own cycle count for the long hold-off
    int  idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    segment_box_clip DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .box_min_x(bmin[0]), .box_min_y(bmin[1]), .box_min_z(bmin[2]),
        .box_max_x(bmax[0]), .box_max_y(bmax[1]), .box_max_z(bmax[2]),
        .seg_start_x(ps[0]), .seg_start_y(ps[1]), .seg_start_z(ps[2]),
        .seg_end_x(pe[0]), .seg_end_y(pe[1]), .seg_end_z(pe[2]),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
        .enter_param(enter_param), .exit_param(exit_param),
        .clip_start_x(cs[0]), .clip_start_y(cs[1]), .clip_start_z(cs[2]),
        .clip_end_x(ce[0]), .clip_end_y(ce[1]), .clip_end_z(ce[2])
    );

    sbc_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .box_min_x(bmin[0]), .box_min_y(bmin[1]), .box_min_z(bmin[2]),
        .box_max_x(bmax[0]), .box_max_y(bmax[1]), .box_max_z(bmax[2]),
        .seg_start_x(ps[0]), .seg_start_y(ps[1]), .seg_start_z(ps[2]),
        .seg_end_x(pe[0]), .seg_end_y(pe[1]), .seg_end_z(pe[2]),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
        .enter_param(enter_param), .exit_param(exit_param),
        .clip_start_x(cs[0]), .clip_start_y(cs[1]), .clip_start_z(cs[2]),
        .clip_end_x(ce[0]), .clip_end_y(ce[1]), .clip_end_z(ce[2]),
        .fail_count(fail_count), .pending(pending)
    );

    // Receiver: random stalls, one long hold-off at a fixed cycle count.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_cycle  <= 0;
            out_ready <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                out_ready <= 1'b0;
            else
                out_ready <= quiet_mode || ($urandom_range(99) >= 20);
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Coordinate picker: mix of small values, box-scale values, full range and extremes.
    function automatic logic [COORD_W-1:0] pick_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(2 * 65536 * 40)) - 65536 * 40;
            2: return $signed($urandom_range(64)) - 32;
            default: return ($urandom_range(3) == 0) ? 32'h8000_0000 :
                            ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h0);
        endcase
    endfunction

    // Offer one segment/box and hold it until accepted; idles before it at random.
    task automatic send_item(input logic [COORD_W-1:0] v[12]);
        while (!quiet_mode && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        for (int a = 0; a < 3; a++)
        begin
            bmin[a] <= v[a];
            bmax[a] <= v[3 + a];
            ps[a]   <= v[6 + a];
            pe[a]   <= v[9 + a];
        end
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic random_item();
        logic [COORD_W-1:0] v[12];
        int mode;
        int lo;
        int hi;
        mode = $urandom_range(9);
        for (int a = 0; a < 3; a++)
        begin
            if (mode < 7)
            begin
                // box around the origin region (sometimes inverted), segment endpoints near it
                lo = pick_coord(1);
                hi = lo + $urandom_range(65536 * 30);
                if ($urandom_range(19) == 0) hi = lo - $urandom_range(1000) - 1;
                v[a] = lo;
                v[3 + a] = hi;
                v[6 + a] = pick_coord($urandom_range(8) == 0 ? 2 : 1);
                v[9 + a] = ($urandom_range(9) == 0) ? v[6 + a] : pick_coord(1);
            end
            else
            begin
                for (int k = 0; k < 4; k++) v[3 * k + a] = pick_coord(mode == 9 ? 3 : 0);
            end
        end
        send_item(v);
    endtask

    initial
    begin
        logic [COORD_W-1:0] v[12];
        int wait_cycles;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fully inside, crossing each axis both ways, zero direction in and out,
        // inverted box, full-range extremes, touching planes.
        v = '{-65536, -65536, -65536, 65536, 65536, 65536, 0, 0, 0, 32768, 0, 0};
        send_item(v);
        for (int a = 0; a < 3; a++)
        begin
            v = '{-65536, -65536, -65536, 65536, 65536, 65536, 0, 0, 0, 0, 0, 0};
            v[6 + a] = -3 * 65536; v[9 + a] = 3 * 65536;
            send_item(v);
            v[6 + a] = 3 * 65536; v[9 + a] = -3 * 65536;
            send_item(v);
            v[6 + a] = 2 * 65536; v[9 + a] = 2 * 65536;
            send_item(v);
            v[6 + a] = 65536; v[9 + a] = 65536;
            send_item(v);
            v[6 + a] = 0; v[9 + a] = 0; v[a] = 65536; v[3 + a] = -65536;
            send_item(v);
        end
        v = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        send_item(v);
        v = '{0, 0, 0, 1, 1, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        send_item(v);
        v = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_item(v);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            quiet_mode = (i >= 400 && i < 600);
            random_item();
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
